### rtl/pae_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the pool allocator with oldest-entry eviction.
// Used by pae_ctrl, pae_datapath and the top level; depends on nothing.
package pae_pkg;

	localparam int HANDLE_W  = 9;
	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_INACTIVE = 1'b1;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;       // take a new request beat, clear result fields
		logic load_evict; // target the oldest active entry and flag it as victim
		logic mark_err;   // report a free of an inactive or out-of-range slot
		logic rd_tgt;     // read link memories at the target
		logic rd_head;    // read link memories at the free-list head
		logic unlink;     // splice target out of the active list
		logic push;       // put target on the free list
		logic pop;        // take free-list head, make it newest
		logic link;       // back-link old newest to the granted entry
		logic emit;       // load the output register
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic in_kind;
		logic in_slot_ok;
		logic head_none;
		logic oldest_none;
		logic active;
	} sts_t;

endpackage

### rtl/pae_datapath.sv
`timescale 1ns / 1ps
// Link memories, list pointers and result registers of the pool allocator.
// Depends on pae_pkg; sequenced by pae_ctrl through cmd_t and sts_t.
module pae_datapath #(
	parameter int ENTRIES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pae_pkg::cmd_t                 cmd,
	output pae_pkg::sts_t                 sts,
	input  logic [pae_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [pae_pkg::S_TUSER_W-1:0] s_tuser,
	output logic [pae_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [pae_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LW = $clog2(ENTRIES + 1);
	localparam logic [LW-1:0] NONE = LW'(ENTRIES);

	logic [LW-1:0] next_mem  [ENTRIES];
	logic [LW-1:0] prev_mem  [ENTRIES];
	logic          inuse_mem [ENTRIES];

	logic [LW-1:0] free_head_q, newest_q, oldest_q;
	// Entries at or above fresh_q were never allocated: next link is i+1, not in use.
	logic [LW-1:0] fresh_q;
	logic [AW-1:0] tgt_q;

	logic [LW-1:0] rd_next_q, rd_prev_q;
	logic          rd_inuse_q, rd_fresh_q;

	logic [pae_pkg::HANDLE_W-1:0] granted_q, victim_q;
	logic                         evicted_q, status_q;

	logic [pae_pkg::HANDLE_W-1:0] in_slot;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;
	logic [LW-1:0]                next_eff;

	logic          nx_we, pv_we, iu_we;
	logic [AW-1:0] nx_wa, pv_wa, iu_wa;
	logic [LW-1:0] nx_wd, pv_wd;
	logic          iu_wd;

	assign in_slot  = s_tdata[pae_pkg::HANDLE_W-1:0];
	assign rd_en    = cmd.rd_tgt | cmd.rd_head;
	assign rd_addr  = cmd.rd_head ? free_head_q[AW-1:0] : tgt_q;
	assign next_eff = rd_fresh_q ? (LW'(tgt_q) + LW'(1)) : rd_next_q;

	assign sts.in_kind     = s_tuser[0];
	assign sts.in_slot_ok  = (32'(in_slot) < ENTRIES);
	assign sts.head_none   = (free_head_q == NONE);
	assign sts.oldest_none = (oldest_q == NONE);
	assign sts.active      = rd_inuse_q & ~rd_fresh_q;

	// One write per memory per cycle; the sequencer never asks for two.
	always_comb begin
		nx_we = 1'b0; nx_wa = tgt_q; nx_wd = NONE;
		pv_we = 1'b0; pv_wa = tgt_q; pv_wd = NONE;
		iu_we = 1'b0; iu_wa = tgt_q; iu_wd = 1'b0;
		if (cmd.unlink) begin
			nx_we = (rd_prev_q != NONE);
			nx_wa = rd_prev_q[AW-1:0];
			nx_wd = next_eff;
			pv_we = (next_eff != NONE);
			pv_wa = next_eff[AW-1:0];
			pv_wd = rd_prev_q;
		end
		if (cmd.push) begin
			nx_we = 1'b1;
			nx_wd = free_head_q;
			iu_we = 1'b1;
			iu_wd = 1'b0;
		end
		if (cmd.pop) begin
			nx_we = 1'b1;
			nx_wd = newest_q;
			pv_we = 1'b1;
			pv_wd = NONE;
			iu_we = 1'b1;
			iu_wd = 1'b1;
		end
		if (cmd.link) begin
			pv_we = (newest_q != NONE);
			pv_wa = newest_q[AW-1:0];
			pv_wd = LW'(tgt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		if (iu_we) inuse_mem[iu_wa] <= iu_wd;
		if (rd_en) begin
			rd_next_q  <= next_mem[rd_addr];
			rd_prev_q  <= prev_mem[rd_addr];
			rd_inuse_q <= inuse_mem[rd_addr];
			rd_fresh_q <= (LW'(rd_addr) >= fresh_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			newest_q    <= NONE;
			oldest_q    <= NONE;
			fresh_q     <= '0;
		end else begin
			if (cmd.unlink) begin
				if (rd_prev_q == NONE) newest_q <= next_eff;
				if (next_eff == NONE) oldest_q <= rd_prev_q;
			end
			if (cmd.push) free_head_q <= LW'(tgt_q);
			if (cmd.pop) begin
				free_head_q <= next_eff;
				// fresh entries leave the free list in index order
				if (rd_fresh_q) fresh_q <= fresh_q + LW'(1);
			end
			if (cmd.link) begin
				if (newest_q == NONE) oldest_q <= LW'(tgt_q);
				newest_q <= LW'(tgt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q     <= cmd.load_evict ? oldest_q[AW-1:0] : AW'(in_slot);
			granted_q <= '0;
			evicted_q <= cmd.load_evict;
			victim_q  <= cmd.load_evict ? pae_pkg::HANDLE_W'(oldest_q) : '0;
			status_q  <= cmd.mark_err ? pae_pkg::STATUS_INACTIVE : pae_pkg::STATUS_OK;
		end else begin
			if (cmd.rd_head) tgt_q <= free_head_q[AW-1:0];
			if (cmd.mark_err) status_q <= pae_pkg::STATUS_INACTIVE;
			if (cmd.link) granted_q <= pae_pkg::HANDLE_W'(tgt_q);
		end
		if (cmd.emit) begin
			m_tdata <= {(pae_pkg::M_TDATA_W - 2 * pae_pkg::HANDLE_W)'(0), victim_q, granted_q};
			m_tuser <= {status_q, evicted_q};
		end
	end

endmodule

### rtl/pae_ctrl.sv
`timescale 1ns / 1ps
// Request sequencer of the pool allocator: steps each request through the
// link-memory reads and writes. Depends on pae_pkg; drives pae_datapath.
module pae_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  pae_pkg::sts_t sts,
	output pae_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FREAD = 4'd1;
	localparam logic [3:0] ST_FCHK  = 4'd2;
	localparam logic [3:0] ST_FUNL  = 4'd3;
	localparam logic [3:0] ST_FPUSH = 4'd4;
	localparam logic [3:0] ST_AREAD = 4'd5;
	localparam logic [3:0] ST_APOP  = 4'd6;
	localparam logic [3:0] ST_ALINK = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       kind_q;
	logic       out_valid_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (sts.in_kind == pae_pkg::KIND_FREE) begin
						if (sts.in_slot_ok) begin
							state_d = ST_FREAD;
						end else begin
							cmd.mark_err = 1'b1;
							state_d      = ST_DONE;
						end
					end else if (!sts.head_none) begin
						state_d = ST_AREAD;
					end else if (!sts.oldest_none) begin
						cmd.load_evict = 1'b1;
						state_d        = ST_FREAD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FREAD: begin
				cmd.rd_tgt = 1'b1;
				state_d    = ST_FCHK;
			end
			ST_FCHK: begin
				if (sts.active) begin
					state_d = ST_FUNL;
				end else begin
					cmd.mark_err = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_FUNL: begin
				cmd.unlink = 1'b1;
				state_d    = ST_FPUSH;
			end
			ST_FPUSH: begin
				cmd.push = 1'b1;
				state_d  = (kind_q == pae_pkg::KIND_ALLOC) ? ST_AREAD : ST_DONE;
			end
			ST_AREAD: begin
				cmd.rd_head = 1'b1;
				state_d     = ST_APOP;
			end
			ST_APOP: begin
				cmd.pop = 1'b1;
				state_d = ST_ALINK;
			end
			ST_ALINK: begin
				cmd.link = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				// hold the result until the output register is free
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= pae_pkg::KIND_ALLOC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) kind_q <= sts.in_kind;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/pool_allocator_evict_oldest.sv
`timescale 1ns / 1ps
// Top level of the pool allocator with oldest-entry eviction.
// Depends on pae_pkg, pae_ctrl and pae_datapath.

// Hands out slots of a pool of ENTRIES from a free list and keeps active slots
// in a newest-to-oldest list; an allocate with no free slot reclaims the oldest
// active slot and reports it as the victim. One request is worked at a time,
// through single-port link memories, one dependent access per cycle. An allocate
// reads, pops and links the free-list head; if it evicts, it first reads, checks,
// unlinks and pushes the oldest slot, as a free does with its slot. A free stops
// after the check if the slot is inactive and goes straight to the result if out
// of range. A result waits on m_tready while the output register is full; the next
// request is taken while a result waits. The link memories are not cleared after
// reset: a fill counter stands for never-used slots, so requests are taken from the first cycle.
module pool_allocator_evict_oldest #(
	parameter int ENTRIES = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pae_pkg::S_TDATA_W-1:0] s_tdata,  // [8:0] slot, rest zero
	input  logic [pae_pkg::S_TUSER_W-1:0] s_tuser,  // [0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pae_pkg::M_TDATA_W-1:0] m_tdata,  // [8:0] granted, [17:9] victim
	output logic [pae_pkg::M_TUSER_W-1:0] m_tuser   // [0] evicted, [1] status
);

	pae_pkg::cmd_t cmd;
	pae_pkg::sts_t sts;

	pae_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pae_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

### rtl/pae_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the pool allocator, bound to the top level.
// Depends on pae_pkg for port widths.
module pae_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pae_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [pae_pkg::M_TUSER_W-1:0] m_tuser
);

	// a beat stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat dropped or changed while stalled");

	// one request in flight: ready drops after every accepted beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// an eviction only comes with a successful allocate
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("eviction reported with error status");

	// a failed free grants nothing and evicts nothing
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0)
		else $error("error result carries nonzero fields");

endmodule

bind pool_allocator_evict_oldest pae_checker u_pae_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
